/* sv/mpp_pkg.sv */
// shared types, codes and helpers for the five-stage mips subset pipeline
package mpp_pkg;

    localparam logic [2:0] MODE_LD_INSTR = 3'd0;
    localparam logic [2:0] MODE_LD_DATA  = 3'd1;
    localparam logic [2:0] MODE_STEP     = 3'd2;
    localparam logic [2:0] MODE_RD_REG   = 3'd3;
    localparam logic [2:0] MODE_RD_DATA  = 3'd4;

    localparam logic [5:0]  OP_RTYPE  = 6'd0;
    localparam logic [5:0]  OP_BRANCH = 6'd4;
    localparam logic [5:0]  OP_LOAD   = 6'd35;
    localparam logic [5:0]  OP_STORE  = 6'd43;
    localparam logic [5:0]  FUNCT_SUB = 6'd35;
    localparam logic [31:0] STOP_WORD = 32'hffff_ffff;

    typedef struct packed {
        logic [2:0] mode;
        logic [9:0] mem_address;
        logic [7:0] byte_value;
        logic [4:0] reg_index;
    } t_in;

    typedef struct packed {
        logic [31:0] fetch_pc;
        logic        halted;
        logic        reg_write_enable;
        logic [4:0]  reg_write_index;
        logic [31:0] reg_write_data;
        logic        mem_write_enable;
        logic [9:0]  mem_write_address;
        logic [31:0] mem_write_data;
        logic [31:0] read_value;
    } t_out;

    typedef struct packed {
        logic [15:0] imm;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  dest;
        logic        itype;
        logic        load;
        logic        store;
        logic        add;
        logic        wen;
        logic        bubble;
    } t_ex_ctl;

    typedef struct packed {
        logic [4:0] dest;
        logic       load;
        logic       store;
        logic       wen;
        logic       bubble;
    } t_mem_ctl;

    typedef struct packed {
        logic [4:0] dest;
        logic       wen;
        logic       bubble;
    } t_wb_ctl;

    // mask bit 3 is the first (most significant) byte of the word
    typedef struct packed {
        logic [3:0]  mask;
        logic [31:0] addr;
        logic [31:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic        en;
        logic [4:0]  idx;
        logic [31:0] data;
    } t_rf_wr;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [7:0] get_byte(input logic [31:0] w, input logic [1:0] i);
        logic [7:0] b;
        case (i)
            2'd0:    b = w[31:24];
            2'd1:    b = w[23:16];
            2'd2:    b = w[15:8];
            default: b = w[7:0];
        endcase
        return b;
    endfunction

endpackage

/* sv/mpp_chan_if.sv */
// valid/ready channel carrying one word of a given payload type
interface mpp_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/mpp_mem.sv */
// byte-addressed big-endian word memory in four byte banks, registered read with bypass
module mpp_mem #(
    parameter int MEM_BYTES = 1024
) (
    input  logic                  i_clk,
    input  mpp_pkg::t_mem_wr      i_wr,
    input  logic [31:0]           i_rd_addr,
    output logic [31:0]           o_rd_word
);
    import mpp_pkg::*;

    localparam int AW   = $clog2(MEM_BYTES);
    localparam int ROWS = MEM_BYTES / 4;
    localparam int RW   = AW - 2;

    logic [7:0] lane_q [4];
    logic [1:0] r_sel;

    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic [7:0]    r_mem [ROWS];
        logic [1:0]    wi;
        logic [1:0]    ri;
        logic [AW-1:0] waddr;
        logic [AW-1:0] raddr;
        logic [RW-1:0] wrow;
        logic [RW-1:0] rrow;
        logic          we;
        logic [7:0]    wdat;
        logic [7:0]    r_rd;
        logic [7:0]    r_byp;
        logic          r_hit;

        always_comb begin
            wi    = 2'(l) - i_wr.addr[1:0];
            ri    = 2'(l) - i_rd_addr[1:0];
            waddr = AW'(i_wr.addr) + AW'(wi);
            raddr = AW'(i_rd_addr) + AW'(ri);
            wrow  = waddr[AW-1:2];
            rrow  = raddr[AW-1:2];
            we    = i_wr.mask[2'd3 - wi];
            wdat  = get_byte(i_wr.data, wi);
        end

        always_ff @(posedge i_clk) begin
            if (we) begin
                r_mem[wrow] <= wdat;
            end
            r_rd  <= r_mem[rrow];
            r_hit <= we && (wrow == rrow);
            r_byp <= wdat;
        end

        assign lane_q[l] = r_hit ? r_byp : r_rd;
    end

    always_ff @(posedge i_clk) begin
        r_sel <= i_rd_addr[1:0];
    end

    assign o_rd_word = {lane_q[r_sel], lane_q[r_sel + 2'd1],
                        lane_q[r_sel + 2'd2], lane_q[r_sel + 2'd3]};
endmodule

/* sv/mpp_regfile.sv */
// 32-entry register file, two registered read ports with write bypass
module mpp_regfile (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mpp_pkg::t_rf_wr  i_wr,
    input  logic [4:0]       i_ra,
    input  logic [4:0]       i_rb,
    output logic [31:0]      o_a,
    output logic [31:0]      o_b
);
    import mpp_pkg::*;

    logic [31:0] r_mem [32];
    logic [31:0] r_valid;
    logic [31:0] r_rd_a;
    logic [31:0] r_rd_b;
    logic [31:0] r_byp;
    logic        r_hit_a;
    logic        r_hit_b;
    logic        r_ok_a;
    logic        r_ok_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ok_a  <= 1'b0;
            r_ok_b  <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.idx] <= 1'b1;
            end
            r_ok_a <= r_valid[i_ra] || (i_wr.en && i_wr.idx == i_ra);
            r_ok_b <= r_valid[i_rb] || (i_wr.en && i_wr.idx == i_rb);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
        r_rd_a  <= r_mem[i_ra];
        r_rd_b  <= r_mem[i_rb];
        r_byp   <= i_wr.data;
        r_hit_a <= i_wr.en && i_wr.idx == i_ra;
        r_hit_b <= i_wr.en && i_wr.idx == i_rb;
    end

    assign o_a = !r_ok_a ? 32'd0 : (r_hit_a ? r_byp : r_rd_a);
    assign o_b = !r_ok_b ? 32'd0 : (r_hit_b ? r_byp : r_rd_b);
endmodule

/* sv/five_stage_mips_subset_pipeline_unit.sv */
// top level: five-stage mips subset pipeline that advances by one step per step word
//
//  channel  dir  payload                                  handshake
//  i_in     in   mode, mem_address, byte_value, reg_index  valid/ready
//  o_out    out  fetch_pc, halted, writes, read_value      valid/ready
//
// one word per cycle while the output is not stalled; each word waits in the input register and
// its result sits in the output register; memory reads are addressed from next-state values
// after reset the memories are cleared one row per cycle, all MEM_BYTES/4 rows,
// with ready low; MEM_BYTES must be a power of two, which the block does not check
// a stalled output holds the input register, and ready drops once that register is full
module five_stage_mips_subset_pipeline_unit #(
    parameter int MEM_BYTES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mpp_chan_if.sink    i_in,
    mpp_chan_if.source  o_out
);
    import mpp_pkg::*;

    localparam int AW   = $clog2(MEM_BYTES);
    localparam int ROWS = MEM_BYTES / 4;
    localparam int RW   = AW - 2;

    logic          r_clr_busy;
    logic [RW-1:0] r_clr_row;
    logic          r_in_valid;
    t_in           r_in;
    logic          r_out_valid;
    t_out          r_out;

    logic [31:0] r_fetch_pc,  n_fetch_pc;
    logic        r_fetch_idle, n_fetch_idle;
    logic [31:0] r_dec_word,  n_dec_word;
    logic        r_dec_idle,  n_dec_idle;
    logic [31:0] r_ex_a,      n_ex_a;
    logic [31:0] r_ex_b,      n_ex_b;
    t_ex_ctl     r_ex_ctl,    n_ex_ctl;
    logic [31:0] r_mem_alu,   n_mem_alu;
    logic [31:0] r_mem_st,    n_mem_st;
    t_mem_ctl    r_mem_ctl,   n_mem_ctl;
    logic [31:0] r_wb_val,    n_wb_val;
    t_wb_ctl     r_wb_ctl,    n_wb_ctl;
    t_out        n_out;

    logic        adv, acc, halted, is_step;
    t_in         q;
    logic        wb_fwd, mem_fwd, stall, taken;
    logic [31:0] iword, dword, rf_a, rf_b;
    logic [31:0] mem_result, fa, fb, src, alu, va, vb, target;
    logic [5:0]  op, funct;
    logic [4:0]  rs, rt, rd;
    logic [15:0] imm;
    logic        rtype, branch, is_load, is_store;
    t_mem_wr     imem_wr, dmem_wr;
    t_rf_wr      rf_wr;
    logic [31:0] dmem_rd_addr;
    logic [4:0]  rf_ra, rf_rb;

    assign adv    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_clr_busy && (!r_in_valid || adv);
    assign acc    = i_in.valid && i_in.ready;
    assign q      = acc ? i_in.data : r_in;
    assign halted = r_fetch_idle && r_dec_idle && r_ex_ctl.bubble &&
                    r_mem_ctl.bubble && r_wb_ctl.bubble;
    assign is_step = adv && r_in.mode == MODE_STEP && !halted;

    // decode fields
    assign op      = r_dec_word[31:26];
    assign rs      = r_dec_word[25:21];
    assign rt      = r_dec_word[20:16];
    assign rd      = r_dec_word[15:11];
    assign funct   = r_dec_word[5:0];
    assign imm     = r_dec_word[15:0];
    assign rtype   = op == OP_RTYPE;
    assign branch  = op == OP_BRANCH;
    assign is_load = op == OP_LOAD;
    assign is_store = op == OP_STORE;

    assign wb_fwd  = !r_wb_ctl.bubble && r_wb_ctl.wen && r_wb_ctl.dest != 5'd0;
    assign mem_fwd = !r_mem_ctl.bubble && r_mem_ctl.wen && r_mem_ctl.dest != 5'd0;
    assign stall   = !r_dec_idle && !r_ex_ctl.bubble && r_ex_ctl.load &&
                     (rs == r_ex_ctl.dest || (rtype && rt == r_ex_ctl.dest));

    always_comb begin
        mem_result = (!r_mem_ctl.store && r_mem_ctl.load) ? dword : r_mem_alu;

        fa = r_ex_a;
        fb = r_ex_b;
        if (wb_fwd && r_wb_ctl.dest == r_ex_ctl.rs) fa = r_wb_val;
        if (wb_fwd && r_wb_ctl.dest == r_ex_ctl.rt) fb = r_wb_val;
        if (mem_fwd && r_mem_ctl.dest == r_ex_ctl.rs) fa = mem_result;
        if (mem_fwd && r_mem_ctl.dest == r_ex_ctl.rt) fb = mem_result;
        src = r_ex_ctl.itype ? sext16(r_ex_ctl.imm) : fb;
        alu = r_ex_ctl.add ? fa + src : fa - src;
        if (!r_ex_ctl.itype && !r_ex_ctl.wen) alu = 32'd0;

        // writeback lands before decode reads
        va = (wb_fwd && r_wb_ctl.dest == rs) ? r_wb_val : rf_a;
        vb = (wb_fwd && r_wb_ctl.dest == rt) ? r_wb_val : rf_b;
        taken  = !r_dec_idle && !stall && branch && va != vb;
        target = r_fetch_pc + {{14{imm[15]}}, imm, 2'b00};
    end

    always_comb begin
        n_fetch_pc   = r_fetch_pc;
        n_fetch_idle = r_fetch_idle;
        n_dec_word   = r_dec_word;
        n_dec_idle   = r_dec_idle;
        n_ex_a       = r_ex_a;
        n_ex_b       = r_ex_b;
        n_ex_ctl     = r_ex_ctl;
        n_mem_alu    = r_mem_alu;
        n_mem_st     = r_mem_st;
        n_mem_ctl    = r_mem_ctl;
        n_wb_val     = r_wb_val;
        n_wb_ctl     = r_wb_ctl;
        if (is_step) begin
            if (r_mem_ctl.bubble) begin
                n_wb_ctl.bubble = 1'b1;
            end else begin
                n_wb_val        = mem_result;
                n_wb_ctl.dest   = r_mem_ctl.dest;
                n_wb_ctl.wen    = r_mem_ctl.wen;
                n_wb_ctl.bubble = 1'b0;
            end

            if (r_ex_ctl.bubble) begin
                n_mem_ctl.bubble = 1'b1;
            end else begin
                n_mem_alu        = alu;
                n_mem_st         = fb;
                n_mem_ctl.dest   = r_ex_ctl.dest;
                n_mem_ctl.load   = r_ex_ctl.load;
                n_mem_ctl.store  = r_ex_ctl.store;
                n_mem_ctl.wen    = r_ex_ctl.wen;
                n_mem_ctl.bubble = 1'b0;
            end

            if (r_dec_idle || stall) begin
                n_ex_ctl.bubble = 1'b1;
            end else begin
                n_ex_a          = va;
                n_ex_b          = vb;
                n_ex_ctl.imm    = imm;
                n_ex_ctl.rs     = rs;
                n_ex_ctl.rt     = rt;
                n_ex_ctl.dest   = rtype ? rd : rt;
                n_ex_ctl.itype  = !rtype && !branch;
                n_ex_ctl.load   = is_load;
                n_ex_ctl.store  = is_store;
                n_ex_ctl.add    = rtype ? (funct != FUNCT_SUB) : 1'b1;
                n_ex_ctl.wen    = !(is_store || branch);
                n_ex_ctl.bubble = 1'b0;
            end

            if (stall) begin
                n_dec_idle = r_dec_idle;
            end else if (taken) begin
                n_fetch_pc   = target;
                n_fetch_idle = 1'b0;
                n_dec_idle   = 1'b1;
            end else if (r_fetch_idle) begin
                n_dec_idle = 1'b1;
            end else begin
                n_dec_word = iword;
                if (iword == STOP_WORD) begin
                    n_fetch_idle = 1'b1;
                    n_dec_idle   = 1'b1;
                end else begin
                    n_dec_idle = 1'b0;
                    n_fetch_pc = r_fetch_pc + 32'd4;
                end
            end
        end
    end

    // memory and register file ports
    always_comb begin
        imem_wr = '0;
        dmem_wr = '0;
        if (r_clr_busy) begin
            imem_wr.mask = 4'b1111;
            imem_wr.addr = 32'({r_clr_row, 2'b00});
            dmem_wr.mask = 4'b1111;
            dmem_wr.addr = 32'({r_clr_row, 2'b00});
        end else if (adv && r_in.mode == MODE_LD_INSTR) begin
            imem_wr.mask = 4'b1000;
            imem_wr.addr = 32'(r_in.mem_address);
            imem_wr.data = {r_in.byte_value, 24'd0};
        end else if (adv && r_in.mode == MODE_LD_DATA) begin
            dmem_wr.mask = 4'b1000;
            dmem_wr.addr = 32'(r_in.mem_address);
            dmem_wr.data = {r_in.byte_value, 24'd0};
        end else if (is_step && !r_mem_ctl.bubble && r_mem_ctl.store) begin
            dmem_wr.mask = 4'b1111;
            dmem_wr.addr = r_mem_alu;
            dmem_wr.data = r_mem_st;
        end
        rf_wr.en   = is_step && wb_fwd;
        rf_wr.idx  = r_wb_ctl.dest;
        rf_wr.data = r_wb_val;
        dmem_rd_addr = (q.mode == MODE_RD_DATA) ? 32'(q.mem_address) : n_mem_alu;
        rf_ra = (q.mode == MODE_RD_REG) ? q.reg_index : n_dec_word[25:21];
        rf_rb = n_dec_word[20:16];
    end

    mpp_mem #(.MEM_BYTES(MEM_BYTES)) u_imem (
        .i_clk     (i_clk),
        .i_wr      (imem_wr),
        .i_rd_addr (n_fetch_pc),
        .o_rd_word (iword)
    );

    mpp_mem #(.MEM_BYTES(MEM_BYTES)) u_dmem (
        .i_clk     (i_clk),
        .i_wr      (dmem_wr),
        .i_rd_addr (dmem_rd_addr),
        .o_rd_word (dword)
    );

    mpp_regfile u_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (rf_wr),
        .i_ra    (rf_ra),
        .i_rb    (rf_rb),
        .o_a     (rf_a),
        .o_b     (rf_b)
    );

    always_comb begin
        n_out          = '0;
        n_out.fetch_pc = n_fetch_pc;
        n_out.halted   = halted;
        if (is_step && wb_fwd) begin
            n_out.reg_write_enable = 1'b1;
            n_out.reg_write_index  = r_wb_ctl.dest;
            n_out.reg_write_data   = r_wb_val;
        end
        if (is_step && !r_mem_ctl.bubble && r_mem_ctl.store) begin
            n_out.mem_write_enable  = 1'b1;
            n_out.mem_write_address = 10'(32'(AW'(r_mem_alu)));
            n_out.mem_write_data    = r_mem_st;
        end
        case (r_in.mode)
            MODE_RD_REG:  n_out.read_value = rf_a;
            MODE_RD_DATA: n_out.read_value = {24'd0, dword[31:24]};
            default:      n_out.read_value = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy   <= 1'b1;
            r_clr_row    <= '0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_fetch_pc   <= '0;
            r_fetch_idle <= 1'b0;
            r_dec_idle   <= 1'b1;
            r_ex_ctl     <= '{add: 1'b1, bubble: 1'b1, default: '0};
            r_mem_ctl    <= '{bubble: 1'b1, default: '0};
            r_wb_ctl     <= '{bubble: 1'b1, default: '0};
        end else begin
            if (r_clr_busy) begin
                r_clr_row <= r_clr_row + 1'b1;
                if (r_clr_row == RW'(ROWS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_fetch_pc   <= n_fetch_pc;
            r_fetch_idle <= n_fetch_idle;
            r_dec_idle   <= n_dec_idle;
            r_ex_ctl     <= n_ex_ctl;
            r_mem_ctl    <= n_mem_ctl;
            r_wb_ctl     <= n_wb_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_in <= i_in.data;
        end
        if (adv) begin
            r_out <= n_out;
        end
        r_dec_word <= n_dec_word;
        r_ex_a     <= n_ex_a;
        r_ex_b     <= n_ex_b;
        r_mem_alu  <= n_mem_alu;
        r_mem_st   <= n_mem_st;
        r_wb_val   <= n_wb_val;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_in.ready)
        else $error("word accepted during memory clear");

    a_stall_holds_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_step && stall |=> $stable(r_fetch_pc) && !r_ex_ctl.bubble == 1'b0)
        else $error("load-use stall moved fetch or issued an instruction");

    a_no_reg0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_wr.en |-> rf_wr.idx != 5'd0)
        else $error("write to register zero");

    a_halted_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.halted |->
            !r_out.reg_write_enable && !r_out.mem_write_enable)
        else $error("write reported while halted");
endmodule
